@@ hw/rtl/jem_pkg.sv @@
// Package with shared types and constants for the Jacobi dominant-eigenvalue block.
package jem_pkg;
  localparam int MAX_ORDER = 8;
  localparam int FRAC_BITS = 16;
  localparam int COEF_BITS = 30;
  localparam int IDX_W = $clog2(MAX_ORDER);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = MAX_ORDER * MAX_ORDER;
  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic [1:0] REG_SIZE  = 2'd0;
  localparam logic [1:0] REG_TOL   = 2'd1;
  localparam logic [1:0] REG_LIMIT = 2'd2;

  typedef struct packed {
    logic signed [31:0] element;
    logic               last;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] eigenvalue;
    logic               limit_hit;
  } out_item_t;

  // Request to the shared square-root / divide unit and its answer.
  typedef struct packed {
    logic        start;
    logic        is_div;
    logic [63:0] num;
    logic [63:0] den;
  } alu_req_t;

  typedef struct packed {
    logic        done;
    logic [63:0] res;
  } alu_rsp_t;
endpackage

@@ hw/rtl/jem_alu.sv @@
// Shared bit-serial unit: 64-bit integer square root or 64/64 unsigned divide.
module jem_alu (
  input  logic              clk,
  input  logic              rst,
  input  jem_pkg::alu_req_t req,
  output jem_pkg::alu_rsp_t rsp
);
  logic        busy;
  logic        done;
  logic        is_div;
  logic [6:0]  step;
  logic [63:0] rem;
  logic [63:0] acc;
  logic [63:0] den;
  logic [63:0] quo;
  logic [63:0] bitv;
  logic [64:0] trial;
  logic [64:0] dtrial;
  logic [63:0] rem_sh;

  assign trial  = {1'b0, rem} - {1'b0, acc | bitv};
  assign rem_sh = {rem[62:0], quo[63]};
  assign dtrial = {1'b0, rem_sh} - {1'b0, den};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
    end else if (req.start) begin
      busy   <= 1'b1;
      is_div <= req.is_div;
      step   <= 7'd0;
      if (req.is_div) begin
        rem <= 64'd0;
        quo <= req.num;
        den <= req.den;
      end else begin
        rem  <= req.num;
        acc  <= 64'd0;
        bitv <= 64'd1 << 62;
      end
    end else if (busy) begin
      step <= step + 7'd1;
      if (is_div) begin
        // Remainder is below den, so den is kept whole and a 65-bit compare decides.
        if (rem[63] || !dtrial[64]) begin
          rem <= rem_sh - den;
          quo <= {quo[62:0], 1'b1};
        end else begin
          rem <= rem_sh;
          quo <= {quo[62:0], 1'b0};
        end
        if (step == 7'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else begin
        if (!trial[64]) begin
          rem <= trial[63:0];
          acc <= (acc >> 1) | bitv;
        end else begin
          acc <= acc >> 1;
        end
        bitv <= bitv >> 2;
        if (step == 7'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp = '{done: done, res: (is_div ? quo : acc)};
endmodule

@@ hw/rtl/jacobi_eigen_max.sv @@
// Top level of the Jacobi-rotation dominant-eigenvalue estimator.
//
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------
//  in       | in_valid/in_ready  | jem_pkg::in_item_t (element, last)
//  out      | out_valid/out_ready| jem_pkg::out_item_t (eigenvalue, limit_hit)
//  config   | APB psel/penable   | matrix_size, tolerance, iteration_limit
//
// Loading accepts one request per cycle. After the request flagged last, the
// block copies the store, then each rotation runs a pivot scan, one square
// root and two pairs of divide and square root on the shared serial unit,
// then row and column updates. A diagonal scan ends the solve. Reset clears
// control state; the store holds garbage until written.
// in_ready is low during the solve and while a result waits at the output.
module jacobi_eigen_max (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  jem_pkg::in_item_t   in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output jem_pkg::out_item_t  out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  localparam int AW = jem_pkg::ADDR_W;
  localparam int IW = jem_pkg::IDX_W;

  typedef enum logic [4:0] {
    S_LOAD, S_COPY, S_COPYW, S_SCAN, S_SCANW, S_DECIDE, S_RDD, S_RDDW, S_RDDW2,
    S_PREP, S_SQ1, S_DIV, S_SQ2, S_UPRD, S_UPRDW, S_UPMUL, S_UPWR, S_MAXRD,
    S_MAXW, S_OUT
  } state_t;

  state_t state;
  logic [3:0]  cfg_size;
  logic [30:0] cfg_tol;
  logic [11:0] cfg_limit;

  // Register file access.
  assign pready = 1'b1;
  always_comb begin
    case (paddr[3:2])
      jem_pkg::REG_SIZE:  prdata = {28'd0, cfg_size};
      jem_pkg::REG_TOL:   prdata = {1'b0, cfg_tol};
      jem_pkg::REG_LIMIT: prdata = {20'd0, cfg_limit};
      default:            prdata = 32'd0;
    endcase
  end

  logic [IW:0] n;
  always_comb begin
    if (cfg_size < 4'd2) n = (IW+1)'(2);
    else if (cfg_size > 4'(jem_pkg::MAX_ORDER)) n = (IW+1)'(jem_pkg::MAX_ORDER);
    else n = cfg_size[IW:0];
  end
  logic [11:0] limit;
  assign limit = (cfg_limit < 12'd2) ? 12'd2 : cfg_limit;

  // Loaded store and working copy; each one write and one registered read.
  logic signed [31:0] store [jem_pkg::DEPTH];
  logic signed [31:0] work  [jem_pkg::DEPTH];
  logic               st_we;
  logic [AW-1:0]      st_wa;
  logic [AW-1:0]      st_ra;
  logic signed [31:0] st_rd;
  logic               wk_we;
  logic [AW-1:0]      wk_wa;
  logic signed [31:0] wk_wd;
  logic [AW-1:0]      wk_ra;
  logic signed [31:0] wk_rd;

  always_ff @(posedge clk) begin
    if (st_we) store[st_wa] <= in_data.element;
    st_rd <= store[st_ra];
    if (wk_we) work[wk_wa] <= wk_wd;
    wk_rd <= work[wk_ra];
  end

  jem_pkg::alu_req_t areq;
  jem_pkg::alu_rsp_t arsp;
  jem_alu u_alu (.clk(clk), .rst(rst), .req(areq), .rsp(arsp));

  logic [jem_pkg::CNT_W-1:0] load_count;
  logic [IW-1:0] lr, lc;             // load row and column
  logic [IW:0]   ci, cj;             // scan/copy/update cursors
  logic [IW:0]   vi, vj;             // cursor of the entry whose read returns now
  logic          rd_pend;
  logic [IW-1:0] pi, pj;
  logic [31:0]   pmag;
  logic [11:0]   rot_count;
  logic signed [32:0] aii, ajj;
  logic [63:0]   ad, ag, r;
  logic          sneg;
  logic          phase2;             // 0: cos, 1: sin
  logic signed [31:0] cc, ss;
  logic          colpass;
  logic [1:0]    ph;
  logic signed [31:0] xv, yv;
  logic signed [31:0] nx, ny;
  logic signed [63:0] p0, p1, p2, p3;
  logic signed [31:0] top;
  logic               top_ok;
  logic               hit;

  logic [31:0] mag_rd;
  assign mag_rd = wk_rd[31] ? 32'd0 - 32'(wk_rd) : 32'(wk_rd);

  function automatic logic signed [31:0] fin(input logic signed [65:0] t);
    logic signed [65:0] q;
    q = (t + (66'sd1 <<< (jem_pkg::COEF_BITS - 1))) >>> jem_pkg::COEF_BITS;
    if (q > 66'sd2147483647) return 32'sh7fffffff;
    if (q < -66'sd2147483648) return 32'sh80000000;
    return q[31:0];
  endfunction

  assign in_ready = (state == S_LOAD) && !out_valid;

  logic [AW-1:0] addr_ij;
  always_comb begin
    addr_ij = {ci[IW-1:0], cj[IW-1:0]};
  end

  always_comb begin
    st_we = (state == S_LOAD) && in_valid && in_ready &&
            (load_count < (jem_pkg::CNT_W)'(n) * (jem_pkg::CNT_W)'(n));
    st_wa = {lr, lc};
    st_ra = addr_ij;
  end

  logic [63:0] ad_n, ag_n;
  logic signed [33:0] d_full, g_full;
  always_comb begin
    d_full = 34'(aii) - 34'(ajj);
    g_full = 34'(xv) <<< 1;
    ad_n = d_full[33] ? 64'(-d_full) : 64'(d_full);
    ag_n = g_full[33] ? 64'(-g_full) : 64'(g_full);
  end

  always_ff @(posedge clk) begin
    areq.start <= 1'b0;
    wk_we <= 1'b0;
    if (rst) begin
      state <= S_LOAD;
      cfg_size <= 4'd8;
      cfg_tol <= 31'd66;
      cfg_limit <= 12'd1024;
      load_count <= '0;
      lr <= '0;
      lc <= '0;
      out_valid <= 1'b0;
      rot_count <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        case (paddr[3:2])
          jem_pkg::REG_SIZE:  cfg_size <= pwdata[3:0];
          jem_pkg::REG_TOL:   cfg_tol <= pwdata[30:0];
          jem_pkg::REG_LIMIT: cfg_limit <= pwdata[11:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) out_valid <= 1'b0;
      case (state)
        S_LOAD: begin
          if (in_valid && in_ready) begin
            if (st_we) begin
              load_count <= load_count + 1'b1;
              if ({1'b0, lc} == n - 1'b1) begin
                lc <= '0;
                lr <= lr + 1'b1;
              end else begin
                lc <= lc + 1'b1;
              end
            end
            if (in_data.last) begin
              load_count <= '0;
              lr <= '0;
              lc <= '0;
              ci <= '0;
              cj <= '0;
              rd_pend <= 1'b0;
              rot_count <= '0;
              hit <= 1'b0;
              state <= S_COPY;
            end
          end
        end
        // Copy the whole store into the working array.
        S_COPY: begin
          rd_pend <= 1'b1;
          vi <= ci;
          vj <= cj;
          if (rd_pend) begin
            wk_we <= 1'b1;
            wk_wa <= {vi[IW-1:0], vj[IW-1:0]};
            wk_wd <= st_rd;
          end
          if (cj == (IW+1)'(jem_pkg::MAX_ORDER - 1)) begin
            cj <= '0;
            if (ci == (IW+1)'(jem_pkg::MAX_ORDER - 1)) state <= S_COPYW;
            else ci <= ci + 1'b1;
          end else begin
            cj <= cj + 1'b1;
          end
        end
        S_COPYW: begin
          wk_we <= 1'b1;
          wk_wa <= {vi[IW-1:0], vj[IW-1:0]};
          wk_wd <= st_rd;
          ci <= '0;
          cj <= (IW+1)'(1);
          rd_pend <= 1'b0;
          pmag <= '0;
          pi <= '0;
          pj <= IW'(1);
          state <= S_SCAN;
        end
        // Pivot scan over the upper triangle, one entry a cycle.
        S_SCAN: begin
          rd_pend <= 1'b1;
          vi <= ci;
          vj <= cj;
          if (rd_pend && mag_rd > pmag) begin
            pmag <= mag_rd;
            pi <= vi[IW-1:0];
            pj <= vj[IW-1:0];
          end
          if (cj == n - 1'b1) begin
            if (ci == n - 2'd2) state <= S_SCANW;
            else begin
              ci <= ci + 1'b1;
              cj <= ci + 2'd2;
            end
          end else begin
            cj <= cj + 1'b1;
          end
        end
        S_SCANW: begin
          if (mag_rd > pmag) begin
            pmag <= mag_rd;
            pi <= vi[IW-1:0];
            pj <= vj[IW-1:0];
          end
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (pmag != 0) begin
            ci <= (IW+1)'(pi);
            cj <= (IW+1)'(pi);
            state <= S_RDD;
          end else begin
            state <= S_UPWR;
            ph <= 2'd3;
          end
        end
        // Fetch a_ii, a_jj and a_ij in turn.
        S_RDD: begin
          ci <= (IW+1)'(pj);
          cj <= (IW+1)'(pj);
          state <= S_RDDW;
        end
        S_RDDW: begin
          aii <= 33'(wk_rd);
          ci <= (IW+1)'(pi);
          cj <= (IW+1)'(pj);
          state <= S_RDDW2;
        end
        S_RDDW2: begin
          ajj <= 33'(wk_rd);
          state <= S_PREP;
          ph <= 2'd0;
        end
        S_PREP: begin
          if (ph == 2'd0) begin
            ph <= 2'd1;
          end else begin
            xv <= wk_rd;
            if (ph == 2'd1) ph <= 2'd2;
            else begin
              sneg <= g_full[33] != d_full[33];
              if (ad_n >= 64'h80000000 || ag_n >= 64'h80000000) begin
                ad <= ad_n >> 2;
                ag <= ag_n >> 2;
              end else begin
                ad <= ad_n;
                ag <= ag_n;
              end
              ph <= 2'd3;
              state <= S_SQ1;
            end
          end
        end
        S_SQ1: begin
          if (ph == 2'd3) begin
            p0 <= 64'(ad[31:0]) * 64'(ad[31:0]);
            p1 <= 64'(ag[31:0]) * 64'(ag[31:0]);
            ph <= 2'd2;
          end else if (ph == 2'd2) begin
            areq.start <= 1'b1;
            areq.is_div <= 1'b0;
            areq.num <= p0 + p1;
            ph <= 2'd1;
          end else if (arsp.done) begin
            r <= arsp.res;
            phase2 <= 1'b0;
            ph <= 2'd0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (ph == 2'd0) begin
            areq.start <= 1'b1;
            areq.is_div <= 1'b1;
            areq.num <= (phase2 ? r - ad : r + ad) << jem_pkg::COEF_BITS;
            areq.den <= r << 1;
            ph <= 2'd1;
          end else if (arsp.done) begin
            areq.start <= 1'b1;
            areq.is_div <= 1'b0;
            areq.num <= arsp.res << jem_pkg::COEF_BITS;
            state <= S_SQ2;
          end
        end
        S_SQ2: begin
          if (arsp.done) begin
            if (!phase2) begin
              cc <= arsp.res[31:0];
              phase2 <= 1'b1;
              ph <= 2'd0;
              state <= S_DIV;
            end else begin
              ss <= sneg ? -arsp.res[31:0] : arsp.res[31:0];
              colpass <= 1'b0;
              ci <= '0;
              state <= S_UPRD;
            end
          end
        end
        // Update pass: row pass reads (i,k),(j,k); column pass (k,i),(k,j).
        S_UPRD: begin
          state <= S_UPRDW;
          ph <= 2'd0;
        end
        S_UPRDW: begin
          if (ph == 2'd0) begin
            xv <= wk_rd;
            ph <= 2'd1;
          end else begin
            yv <= wk_rd;
            state <= S_UPMUL;
            ph <= 2'd0;
          end
        end
        S_UPMUL: begin
          ph <= ph + 1'b1;
          if (ph == 2'd0) begin
            p0 <= 64'(cc) * 64'(xv);
            p1 <= 64'(ss) * 64'(yv);
          end else if (ph == 2'd1) begin
            nx <= fin(66'(p0) + 66'(p1));
            p2 <= 64'(-ss) * 64'(xv);
            p3 <= 64'(cc) * 64'(yv);
          end else begin
            ny <= fin(66'(p2) + 66'(p3));
            ph <= 2'd0;
            state <= S_UPWR;
          end
        end
        S_UPWR: begin
          if (ph == 2'd3) begin
            // Rotation bookkeeping and the stop tests.
            rot_count <= rot_count + 1'b1;
            if (rot_count + 1'b1 >= 12'd2 && pmag <= {1'b0, cfg_tol}) begin
              state <= S_MAXRD;
            end else if (rot_count + 1'b1 >= limit) begin
              hit <= 1'b1;
              state <= S_MAXRD;
            end else begin
              ci <= '0;
              cj <= (IW+1)'(1);
              rd_pend <= 1'b0;
              pmag <= '0;
              pi <= '0;
              pj <= IW'(1);
              state <= S_SCAN;
            end
            ci <= '0;
            ph <= 2'd0;
            if (!(rot_count + 1'b1 >= 12'd2 && pmag <= {1'b0, cfg_tol}) &&
                !(rot_count + 1'b1 >= limit)) ci <= '0;
            top_ok <= 1'b0;
          end else begin
            wk_we <= 1'b1;
            if (ph == 2'd0) begin
              wk_wa <= colpass ? {ci[IW-1:0], pi} : {pi, ci[IW-1:0]};
              wk_wd <= nx;
              ph <= 2'd1;
            end else begin
              wk_wa <= colpass ? {ci[IW-1:0], pj} : {pj, ci[IW-1:0]};
              wk_wd <= ny;
              ph <= 2'd0;
              if (ci == n - 1'b1) begin
                ci <= '0;
                if (colpass) ph <= 2'd3;
                else begin
                  colpass <= 1'b1;
                  state <= S_UPRD;
                end
              end else begin
                ci <= ci + 1'b1;
                state <= S_UPRD;
              end
            end
          end
        end
        // Largest diagonal entry.
        S_MAXRD: begin
          state <= S_MAXW;
          ph <= 2'd0;
        end
        S_MAXW: begin
          if (ph == 2'd0) ph <= 2'd1;
          else begin
            if (!top_ok || wk_rd > top) top <= wk_rd;
            top_ok <= 1'b1;
            if (ci == n - 1'b1) state <= S_OUT;
            else begin
              ci <= ci + 1'b1;
              state <= S_MAXRD;
            end
          end
        end
        S_OUT: begin
          out_valid <= 1'b1;
          out_data.eigenvalue <= top;
          out_data.limit_hit <= hit;
          state <= S_LOAD;
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // Work-array read address follows the phase of the sequencer.
  always_comb begin
    wk_ra = addr_ij;
    case (state)
      S_RDD, S_RDDW: wk_ra = addr_ij;
      S_PREP: wk_ra = {pi, pj};
      S_UPRD: wk_ra = colpass ? {ci[IW-1:0], pi} : {pi, ci[IW-1:0]};
      S_UPRDW: wk_ra = colpass ? {ci[IW-1:0], pj} : {pj, ci[IW-1:0]};
      S_MAXRD, S_MAXW: wk_ra = {ci[IW-1:0], ci[IW-1:0]};
      default: wk_ra = addr_ij;
    endcase
  end

  logic unused_ok;
  assign unused_ok = ^{paddr[1:0]};
endmodule

@@ hw/rtl/jem_checker.sv @@
// Port-level checker for the eigenvalue block, bound to the top level.
module jem_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input jem_pkg::in_item_t  in_data,
  input logic               out_valid,
  input logic               out_ready,
  input jem_pkg::out_item_t out_data
);
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_busy_after_last: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && in_data.last |=> !in_ready)
    else $error("block ready right after a final element");
  a_no_ready_with_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result after reset");
endmodule

bind jacobi_eigen_max jem_checker u_jem_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
  .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
);
